// File: src/buddy_block_allocator_unit_assert.svh
// Assertion shorthands used by the checker of this block.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Clocked assertion with explicit clock and active-low reset.
`define BBA_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Same, on the standard clock and reset port names.
`define BBA_ASSERT(lbl, prop) `BBA_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// File: src/bba_pkg.sv
package bba_pkg;

  localparam int SIZE_W     = 12;
  localparam int INDEX_W    = 11;
  localparam int STATUS_W   = 3;
  localparam int AIDX_W     = 10;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_NOT_ALLOC = 3'd5
  } status_e;

endpackage

// File: src/buddy_block_allocator_unit.sv
// Channel  Dir  Width  Contents (low bit up)
// s_axis   in   24+1   tdata: size_blocks[11:0], block_index[22:12]; tuser: req_type
// m_axis   out  16     tdata: status[2:0], alloc_index[12:3]
//
// After reset, a clearing pass over all NUM_BLOCKS blocks initializes the block marks; no item is
// taken meanwhile. One item at a time: an allocation unlinks a free block and splits it down level
// by level, a free checks the block's mark and merges it with free buddies before pushing it, and a
// rejected item goes to the response without changing the free lists.
// A waiting result holds the output register; the next item is taken meanwhile, but its
// result waits until the previous one is taken.
module buddy_block_allocator_unit #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // size_blocks[11:0], block_index[22:12], zero pad
  input  logic [bba_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[2:0], alloc_index[12:3], zero pad
  output logic [bba_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int TOP_LVL = $clog2(NUM_BLOCKS + 1) - 1;
  localparam int TOTAL   = 1 << TOP_LVL;
  localparam int IW      = $clog2(NUM_BLOCKS);
  localparam int LKW     = $clog2(NUM_BLOCKS + 1);
  localparam int LVW     = $clog2(TOP_LVL + 1);
  localparam int MW      = $clog2(TOP_LVL + 3);

  localparam logic [LKW-1:0] NIL         = LKW'(NUM_BLOCKS);
  localparam logic [MW-1:0]  MARK_FREE   = MW'(TOP_LVL + 1);
  localparam logic [MW-1:0]  MARK_INSIDE = MW'(TOP_LVL + 2);
  localparam logic [LVW-1:0] TOP_L       = LVW'(TOP_LVL);
  localparam logic [IW-1:0]  LAST_BLK    = IW'(NUM_BLOCKS - 1);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_FCHK   = 11'b000_0000_0100,
    S_MERGE  = 11'b000_0000_1000,
    S_MCHK   = 11'b000_0001_0000,
    S_UNLINK = 11'b000_0010_0000,
    S_SPLIT  = 11'b000_0100_0000,
    S_AEND   = 11'b000_1000_0000,
    S_PUSH   = 11'b001_0000_0000,
    S_PLINK  = 11'b010_0000_0000,
    S_RESP   = 11'b100_0000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [IW-1:0]         cur_q, cur_d;
  logic [IW-1:0]         bud_q, bud_d;
  logic [LVW-1:0]        lvl_q, lvl_d;
  logic [LVW-1:0]        tgt_q, tgt_d;
  logic                  free_op_q, free_op_d;
  bba_pkg::status_e      status_q, status_d;
  logic [IW-1:0]         clr_q, clr_d;
  logic [LKW-1:0]        head_q [TOP_LVL+1];
  logic                  m_tvalid_q, m_tvalid_d;
  logic [bba_pkg::OUT_DATA_W-1:0] m_tdata_q, m_tdata_d;

  logic [MW-1:0]         mark_mem  [NUM_BLOCKS];
  logic [LVW-1:0]        level_mem [NUM_BLOCKS];
  logic [LKW-1:0]        next_mem  [NUM_BLOCKS];
  logic [LKW-1:0]        prev_mem  [NUM_BLOCKS];
  logic [MW-1:0]         rd_mark_q;
  logic [LVW-1:0]        rd_level_q;
  logic [LKW-1:0]        rd_next_q;
  logic [LKW-1:0]        rd_prev_q;

  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  mark_we, level_we, next_we, prev_we, head_we;
  logic [IW-1:0]         mark_waddr, level_waddr, next_waddr, prev_waddr;
  logic [MW-1:0]         mark_wdata;
  logic [LVW-1:0]        level_wdata;
  logic [LKW-1:0]        next_wdata, prev_wdata, head_wdata;
  logic [LVW-1:0]        head_waddr;

  logic [bba_pkg::SIZE_W-1:0]  req_size;
  logic [bba_pkg::INDEX_W-1:0] req_index;
  logic                  req_free, size_pow2, size_big, idx_big;
  logic [LVW-1:0]        req_lvl;
  logic                  fnd;
  logic [LVW-1:0]        fnd_lvl;
  logic [IW-1:0]         fnd_head;
  logic [IW-1:0]         bud_addr, upper_addr;
  logic [LVW-1:0]        lvl_dn;
  logic [LKW-1:0]        head_cur;
  logic [bba_pkg::AIDX_W-1:0] out_idx;

  assign req_size  = s_axis_tdata[11:0];
  assign req_index = s_axis_tdata[22:12];
  assign req_free  = (s_axis_tuser[0] == bba_pkg::REQ_FREE);
  assign size_pow2 = (req_size != '0) && ((req_size & (req_size - 12'd1)) == '0);
  assign size_big  = 32'(req_size) > 32'(TOTAL);
  assign idx_big   = 32'(req_index) >= 32'(TOTAL);

  assign bud_addr   = cur_q ^ (IW'(1) << lvl_q);
  assign lvl_dn     = lvl_q - LVW'(1);
  assign upper_addr = cur_q + (IW'(1) << lvl_dn);
  assign head_cur   = head_q[lvl_q];

  always_comb begin
    req_lvl = '0;
    for (int k = 0; k < bba_pkg::SIZE_W; k++) begin
      if (req_size[k]) req_lvl = LVW'(k);
    end
  end

  always_comb begin
    fnd      = 1'b0;
    fnd_lvl  = '0;
    fnd_head = '0;
    for (int l = TOP_LVL; l >= 0; l--) begin
      if ((LVW'(l) >= req_lvl) && (head_q[l] != NIL)) begin
        fnd      = 1'b1;
        fnd_lvl  = LVW'(l);
        fnd_head = head_q[l][IW-1:0];
      end
    end
  end

  assign out_idx = (status_q == bba_pkg::ST_OK && !free_op_q) ?
                   bba_pkg::AIDX_W'(cur_q) : '0;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    bud_d       = bud_q;
    lvl_d       = lvl_q;
    tgt_d       = tgt_q;
    free_op_d   = free_op_q;
    status_d    = status_q;
    clr_d       = clr_q;
    m_tvalid_d  = m_tvalid_q && !m_axis_tready;
    m_tdata_d   = m_tdata_q;
    rd_en       = 1'b0;
    rd_addr     = bud_addr;
    mark_we     = 1'b0;
    mark_waddr  = cur_q;
    mark_wdata  = MARK_FREE;
    level_we    = 1'b0;
    level_waddr = cur_q;
    level_wdata = lvl_q;
    next_we     = 1'b0;
    next_waddr  = cur_q;
    next_wdata  = NIL;
    prev_we     = 1'b0;
    prev_waddr  = cur_q;
    prev_wdata  = NIL;
    head_we     = 1'b0;
    head_waddr  = lvl_q;
    head_wdata  = NIL;

    unique case (state_q)
      S_CLEAR: begin
        mark_we     = 1'b1;
        mark_waddr  = clr_q;
        mark_wdata  = (clr_q == '0) ? MARK_FREE : MARK_INSIDE;
        level_we    = 1'b1;
        level_waddr = clr_q;
        level_wdata = TOP_L;
        next_we     = 1'b1;
        next_waddr  = clr_q;
        prev_we     = 1'b1;
        prev_waddr  = clr_q;
        clr_d       = clr_q + IW'(1);
        if (clr_q == LAST_BLK) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          free_op_d = req_free;
          if (req_free) begin
            if (idx_big) begin
              status_d = bba_pkg::ST_BAD_INDEX;
              state_d  = S_RESP;
            end else begin
              cur_d   = IW'(req_index);
              rd_en   = 1'b1;
              rd_addr = IW'(req_index);
              state_d = S_FCHK;
            end
          end else if (!size_pow2) begin
            status_d = bba_pkg::ST_BAD_SIZE;
            state_d  = S_RESP;
          end else if (size_big) begin
            status_d = bba_pkg::ST_TOO_LARGE;
            state_d  = S_RESP;
          end else if (!fnd) begin
            status_d = bba_pkg::ST_NO_MEM;
            state_d  = S_RESP;
          end else begin
            cur_d   = fnd_head;
            bud_d   = fnd_head;
            lvl_d   = fnd_lvl;
            tgt_d   = req_lvl;
            rd_en   = 1'b1;
            rd_addr = fnd_head;
            state_d = S_UNLINK;
          end
        end
      end
      S_FCHK: begin
        if (rd_mark_q == MARK_FREE || rd_mark_q == MARK_INSIDE) begin
          status_d = bba_pkg::ST_NOT_ALLOC;
          state_d  = S_RESP;
        end else begin
          lvl_d   = rd_mark_q[LVW-1:0];
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        if (lvl_q == TOP_L) begin
          state_d = S_PUSH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = bud_addr;
          bud_d   = bud_addr;
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        if (rd_mark_q == MARK_FREE && rd_level_q == lvl_q) state_d = S_UNLINK;
        else state_d = S_PUSH;
      end
      S_UNLINK: begin
        if (rd_prev_q != NIL) begin
          next_we    = 1'b1;
          next_waddr = rd_prev_q[IW-1:0];
          next_wdata = rd_next_q;
        end else begin
          head_we    = 1'b1;
          head_wdata = rd_next_q;
        end
        if (rd_next_q != NIL) begin
          prev_we    = 1'b1;
          prev_waddr = rd_next_q[IW-1:0];
          prev_wdata = rd_prev_q;
        end
        if (free_op_q) begin
          mark_we    = 1'b1;
          mark_waddr = (bud_q > cur_q) ? bud_q : cur_q;
          mark_wdata = MARK_INSIDE;
          cur_d      = (bud_q > cur_q) ? cur_q : bud_q;
          lvl_d      = lvl_q + LVW'(1);
          state_d    = S_MERGE;
        end else if (lvl_q > tgt_q) begin
          state_d = S_SPLIT;
        end else begin
          state_d = S_AEND;
        end
      end
      S_SPLIT: begin
        mark_we     = 1'b1;
        mark_waddr  = upper_addr;
        mark_wdata  = MARK_FREE;
        level_we    = 1'b1;
        level_waddr = upper_addr;
        level_wdata = lvl_dn;
        next_we     = 1'b1;
        next_waddr  = upper_addr;
        prev_we     = 1'b1;
        prev_waddr  = upper_addr;
        head_we     = 1'b1;
        head_waddr  = lvl_dn;
        head_wdata  = LKW'(upper_addr);
        lvl_d       = lvl_dn;
        if (lvl_dn <= tgt_q) state_d = S_AEND;
      end
      S_AEND: begin
        mark_we    = 1'b1;
        mark_wdata = MW'(tgt_q);
        status_d   = bba_pkg::ST_OK;
        state_d    = S_RESP;
      end
      S_PUSH: begin
        mark_we    = 1'b1;
        level_we   = 1'b1;
        next_we    = 1'b1;
        next_wdata = head_cur;
        prev_we    = 1'b1;
        head_we    = 1'b1;
        head_wdata = LKW'(cur_q);
        status_d   = bba_pkg::ST_OK;
        if (head_cur != NIL) begin
          bud_d   = head_cur[IW-1:0];
          state_d = S_PLINK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_PLINK: begin
        prev_we    = 1'b1;
        prev_waddr = bud_q;
        prev_wdata = LKW'(cur_q);
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {3'b000, out_idx, status_q};
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      m_tvalid_q <= 1'b0;
      free_op_q  <= 1'b0;
      status_q   <= bba_pkg::ST_OK;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      m_tvalid_q <= m_tvalid_d;
      free_op_q  <= free_op_d;
      status_q   <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l <= TOP_LVL; l++) begin
        head_q[l] <= (l == TOP_LVL) ? '0 : NIL;
      end
    end else if (head_we) begin
      head_q[head_waddr] <= head_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    bud_q     <= bud_d;
    lvl_q     <= lvl_d;
    tgt_q     <= tgt_d;
    m_tdata_q <= m_tdata_d;
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    if (rd_en) rd_mark_q <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (level_we) level_mem[level_waddr] <= level_wdata;
    if (rd_en) rd_level_q <= level_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (rd_en) rd_next_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (rd_en) rd_prev_q <= prev_mem[rd_addr];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

// File: src/bba_checker.sv
`include "buddy_block_allocator_unit_assert.svh"

module bba_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [bba_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [0:0]                     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bba_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic out_ok;
  logic in_take;

  assign out_ok  = (m_axis_tdata[2:0] == bba_pkg::ST_OK);
  assign in_take = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '1 || s_axis_tuser != '1);

  `BBA_ASSERT(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `BBA_ASSERT(a_status_range, m_axis_tvalid |-> m_axis_tdata[2:0] <= bba_pkg::ST_NOT_ALLOC)
  `BBA_ASSERT(a_index_only_ok, m_axis_tvalid && !out_ok |-> m_axis_tdata[15:3] == '0)
  `BBA_ASSERT(a_hold_stall, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `BBA_ASSERT(a_take_idle, in_take |=> $past(s_axis_tready))

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (.*);
